// ===== src/bdeq_pkg.sv =====
// Shared constants, codes and controller/datapath command types for the deque.
package bdeq_pkg;

	localparam int DEPTH      = 16;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int KIND_W     = 3;
	localparam int VAL_W      = 32;
	localparam int STATUS_W   = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                push_front;
		logic                push_back;
		logic                pop_front;
		logic                pop_back;
		logic                list_start;
		logic                list_next;
		logic                load_out;
		logic                use_rd;
		logic [STATUS_W-1:0] status;
		logic                last;
	} bdeq_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic empty;
		logic full;
		logic list_end;
		logic out_free;
	} bdeq_stat_t;

endpackage

// ===== src/bdeq_if.sv =====
// Valid/ready channel interfaces for operation requests and results.
interface bdeq_in_if;
	logic                              valid;
	logic                              ready;
	logic [bdeq_pkg::KIND_W-1:0]       kind;
	logic signed [bdeq_pkg::VAL_W-1:0] value;

	modport source (output valid, kind, value, input ready);
	modport sink   (input valid, kind, value, output ready);
endinterface

interface bdeq_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [bdeq_pkg::VAL_W-1:0]   result_value;
	logic [bdeq_pkg::STATUS_W-1:0]       status;
	logic [bdeq_pkg::CNT_W-1:0]          entry_count;
	logic                                last;

	modport source (output valid, result_value, status, entry_count, last, input ready);
	modport sink   (input valid, result_value, status, entry_count, last, output ready);
endinterface

// ===== src/bdeq_ctrl.sv =====
// Controller state machine: decodes each request and sequences pops and list walks.
module bdeq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [bdeq_pkg::KIND_W-1:0]   kind,
	input  bdeq_pkg::bdeq_stat_t          stat,
	output logic                          in_ready,
	output bdeq_pkg::bdeq_cmd_t           cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;

	// Decode the request and step through the walk
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status = bdeq_pkg::STATUS_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind)
						bdeq_pkg::KIND_PUSH_FRONT, bdeq_pkg::KIND_PUSH_BACK: begin
							cmd.load_out = 1'b1;
							cmd.last     = 1'b1;
							if (stat.full) begin
								cmd.status = bdeq_pkg::STATUS_FULL;
							end else begin
								cmd.push_front = (kind == bdeq_pkg::KIND_PUSH_FRONT);
								cmd.push_back  = (kind == bdeq_pkg::KIND_PUSH_BACK);
							end
						end
						bdeq_pkg::KIND_POP_FRONT, bdeq_pkg::KIND_POP_BACK: begin
							if (stat.empty) begin
								cmd.load_out = 1'b1;
								cmd.last     = 1'b1;
								cmd.status   = bdeq_pkg::STATUS_EMPTY;
							end else begin
								cmd.pop_front = (kind == bdeq_pkg::KIND_POP_FRONT);
								cmd.pop_back  = (kind == bdeq_pkg::KIND_POP_BACK);
								state_d       = S_POP;
							end
						end
						bdeq_pkg::KIND_LIST: begin
							if (stat.empty) begin
								cmd.load_out = 1'b1;
								cmd.last     = 1'b1;
								cmd.status   = bdeq_pkg::STATUS_EMPTY;
							end else begin
								cmd.list_start = 1'b1;
								state_d        = S_LIST;
							end
						end
						default: begin
							// drop undefined requests without a result
						end
					endcase
				end
			end
			S_POP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.use_rd   = 1'b1;
					cmd.last     = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_LIST: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.use_rd   = 1'b1;
					cmd.last     = stat.list_end;
					if (stat.list_end) begin
						state_d = S_IDLE;
					end else begin
						cmd.list_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/bdeq_dp.sv =====
// Datapath: ring store, front index, count, list walker and output register.
module bdeq_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [bdeq_pkg::VAL_W-1:0]   value,
	input  bdeq_pkg::bdeq_cmd_t                 cmd,
	input  logic                                out_ready,
	output bdeq_pkg::bdeq_stat_t                stat,
	output logic                                out_valid,
	output logic signed [bdeq_pkg::VAL_W-1:0]   result_value,
	output logic [bdeq_pkg::STATUS_W-1:0]       status,
	output logic [bdeq_pkg::CNT_W-1:0]          entry_count,
	output logic                                last
);

	localparam bdeq_pkg::cnt_t CNT_ONE = bdeq_pkg::cnt_t'(1);
	localparam bdeq_pkg::idx_t IDX_ONE = bdeq_pkg::idx_t'(1);
	localparam bdeq_pkg::cnt_t CNT_FULL = bdeq_pkg::cnt_t'(bdeq_pkg::DEPTH);

	logic signed [bdeq_pkg::VAL_W-1:0] mem [bdeq_pkg::DEPTH];
	logic signed [bdeq_pkg::VAL_W-1:0] rd_data_q;

	bdeq_pkg::idx_t front_q;
	bdeq_pkg::idx_t front_d;
	bdeq_pkg::cnt_t count_q;
	bdeq_pkg::cnt_t count_d;
	bdeq_pkg::cnt_t list_idx_q;
	bdeq_pkg::idx_t wr_addr;
	bdeq_pkg::idx_t rd_addr;
	bdeq_pkg::idx_t back_idx;
	logic           wr_en;
	logic           rd_en;

	logic                              out_valid_q;
	logic signed [bdeq_pkg::VAL_W-1:0] result_value_q;
	logic [bdeq_pkg::STATUS_W-1:0]     status_q;
	bdeq_pkg::cnt_t                    entry_count_q;
	logic                              last_q;

	// Ring addressing: wrap by truncation to the index width
	assign back_idx = front_q + count_q[bdeq_pkg::IDX_W-1:0];

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		if (cmd.push_front) begin
			front_d = front_q - IDX_ONE;
			count_d = count_q + CNT_ONE;
		end else if (cmd.push_back) begin
			count_d = count_q + CNT_ONE;
		end else if (cmd.pop_front) begin
			front_d = front_q + IDX_ONE;
			count_d = count_q - CNT_ONE;
		end else if (cmd.pop_back) begin
			count_d = count_q - CNT_ONE;
		end
	end

	assign wr_en   = cmd.push_front || cmd.push_back;
	assign wr_addr = cmd.push_front ? (front_q - IDX_ONE) : back_idx;
	assign rd_en   = cmd.pop_front || cmd.pop_back || cmd.list_start || cmd.list_next;

	always_comb begin
		if (cmd.pop_back) begin
			rd_addr = back_idx - IDX_ONE;
		end else if (cmd.list_next) begin
			rd_addr = front_q + list_idx_q[bdeq_pkg::IDX_W-1:0];
		end else begin
			rd_addr = front_q;
		end
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Advance front, count and the list offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			count_q    <= '0;
			list_idx_q <= '0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
			if (cmd.list_start) begin
				list_idx_q <= CNT_ONE;
			end else if (cmd.list_next) begin
				list_idx_q <= list_idx_q + CNT_ONE;
			end
		end
	end

	// Output register: load a beat, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_value_q <= cmd.use_rd ? rd_data_q : '0;
			status_q       <= cmd.status;
			entry_count_q  <= count_d;
			last_q         <= cmd.last;
		end
	end

	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q >= CNT_FULL);
	assign stat.list_end = (list_idx_q == count_q);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;
	assign last         = last_q;

endmodule

// ===== src/bounded_double_ended_queue.sv =====
// Top level of the bounded double-ended queue: joins controller and datapath.
//
// A bounded deque of signed 32-bit values (16 entries) kept in a ring store.
// in_ch carries one request per beat: kind (push front, push back, pop front,
// pop back, list) and value. out_ch returns result beats: result_value,
// status (ok, empty, full), entry_count after the operation, and last on the
// final beat of the request. Undefined kinds are taken and give no beat.
// Push and failed operations: the result beat is registered at the accepting
// edge, so it shows in the next cycle; a next request is taken once the output
// register is free. Pop: the store read is registered, then loaded into the
// output register once it is free; no request is taken meanwhile. List: one
// beat per stored value from front to back after a read start, one per cycle
// while the receiver takes them. The single store read port sets this order.
// in_ch.ready is high while no pop or list is in progress and the output
// register is empty or being taken. When the receiver stalls, the pending
// beat holds and the walk pauses. Reset empties the queue at once; the store
// itself is not cleared.
module bounded_double_ended_queue (
	input  logic         clk,
	input  logic         arst_n,
	bdeq_in_if.sink      in_ch,
	bdeq_out_if.source   out_ch
);

	bdeq_pkg::bdeq_cmd_t  cmd;
	bdeq_pkg::bdeq_stat_t stat;

	bdeq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.kind     (in_ch.kind),
		.stat     (stat),
		.in_ready (in_ch.ready),
		.cmd      (cmd)
	);

	bdeq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (in_ch.value),
		.cmd          (cmd),
		.out_ready    (out_ch.ready),
		.stat         (stat),
		.out_valid    (out_ch.valid),
		.result_value (out_ch.result_value),
		.status       (out_ch.status),
		.entry_count  (out_ch.entry_count),
		.last         (out_ch.last)
	);

endmodule

// ===== dv/bdeq_checker.sv =====
// Deque checker: tracks accepted requests, predicts result beats and compares them.
`timescale 1ns / 100ps
module bdeq_checker (
	input  logic clk,
	input  logic arst_n,
	bdeq_in_if   in_ch,
	bdeq_out_if  out_ch,
	output int   error_count,
	output int   waiting_results,
	output int   requests_seen,
	output int   beats_seen,
	output int   full_reports,
	output int   empty_reports
);

	// A list never returns more beats than this
	localparam int LIST_MAX = 16;

	typedef struct packed {
		logic signed [bdeq_pkg::VAL_W-1:0] result_value;
		logic [bdeq_pkg::STATUS_W-1:0]     status;
		bdeq_pkg::cnt_t                    entry_count;
		logic                              last;
	} result_beat_t;

	// Shadow ring of the deque contents
	logic signed [bdeq_pkg::VAL_W-1:0] ring [bdeq_pkg::DEPTH];
	int                                head;
	int                                fill;
	int                                list_len;
	result_beat_t                      pending_results[$];
	result_beat_t                      want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			fill = 0;
			pending_results.delete();
			error_count = 0;
			waiting_results = 0;
			requests_seen = 0;
			beats_seen = 0;
			full_reports = 0;
			empty_reports = 0;
		end else begin
			// Compare each taken result beat with the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				beats_seen++;
				if (pending_results.size() == 0) begin
					$error("unexpected result beat: result_value %0d status %0d last %0b",
						out_ch.result_value, out_ch.status, out_ch.last);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (out_ch.result_value !== want.result_value) begin
						$error("result_value: expected %0d, got %0d",
							want.result_value, out_ch.result_value);
						error_count++;
					end
					if (out_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_ch.status);
						error_count++;
					end
					if (out_ch.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, out_ch.entry_count);
						error_count++;
					end
					if (out_ch.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, out_ch.last);
						error_count++;
					end
					if (want.status == bdeq_pkg::STATUS_FULL)
						full_reports++;
					if (want.status == bdeq_pkg::STATUS_EMPTY)
						empty_reports++;
				end
			end

			// Apply each accepted request to the shadow ring and queue its beats
			if (in_ch.valid && in_ch.ready) begin
				requests_seen++;
				want = '0;
				want.status = bdeq_pkg::STATUS_OK;
				want.last = 1'b1;
				case (in_ch.kind)
				bdeq_pkg::KIND_PUSH_FRONT, bdeq_pkg::KIND_PUSH_BACK: begin
					if (fill >= bdeq_pkg::DEPTH) begin
						want.status = bdeq_pkg::STATUS_FULL;
					end else if (in_ch.kind == bdeq_pkg::KIND_PUSH_FRONT) begin
						head = (head + bdeq_pkg::DEPTH - 1) % bdeq_pkg::DEPTH;
						ring[head] = in_ch.value;
						fill++;
					end else begin
						ring[(head + fill) % bdeq_pkg::DEPTH] = in_ch.value;
						fill++;
					end
					want.entry_count = bdeq_pkg::cnt_t'(fill);
					pending_results.push_back(want);
				end
				bdeq_pkg::KIND_POP_FRONT, bdeq_pkg::KIND_POP_BACK: begin
					if (fill == 0) begin
						want.status = bdeq_pkg::STATUS_EMPTY;
					end else if (in_ch.kind == bdeq_pkg::KIND_POP_FRONT) begin
						want.result_value = ring[head];
						head = (head + 1) % bdeq_pkg::DEPTH;
						fill--;
					end else begin
						want.result_value = ring[(head + fill - 1) % bdeq_pkg::DEPTH];
						fill--;
					end
					want.entry_count = bdeq_pkg::cnt_t'(fill);
					pending_results.push_back(want);
				end
				bdeq_pkg::KIND_LIST: begin
					want.entry_count = bdeq_pkg::cnt_t'(fill);
					if (fill == 0) begin
						want.status = bdeq_pkg::STATUS_EMPTY;
						pending_results.push_back(want);
					end else begin
						// Walk front to back, mark the final beat
						list_len = (fill < LIST_MAX) ? fill : LIST_MAX;
						for (int i = 0; i < list_len; i++) begin
							want.result_value = ring[(head + i) % bdeq_pkg::DEPTH];
							want.last = (i == list_len - 1);
							pending_results.push_back(want);
						end
					end
				end
				default: begin
					// Unused kinds are taken and dropped
				end
				endcase
			end
			waiting_results = pending_results.size();
		end
	end

endmodule

// ===== dv/tb_bounded_double_ended_queue.sv =====
// Testbench top for the bounded deque: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_bounded_double_ended_queue;

	typedef logic [bdeq_pkg::KIND_W-1:0] kind_t;
	typedef logic signed [bdeq_pkg::VAL_W-1:0] value_t;

	localparam value_t VALUE_MIN = 32'sh8000_0000;
	localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;
	localparam int PHASE_ITEMS = 40;

	logic clk;
	logic arst_n;

	bdeq_in_if  in_ch();
	bdeq_out_if out_ch();

	int error_count;
	int waiting_results;
	int requests_seen;
	int beats_seen;
	int full_reports;
	int empty_reports;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_request   = 0;

	bounded_double_ended_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	bdeq_checker deque_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.error_count     (error_count),
		.waiting_results (waiting_results),
		.requests_seen   (requests_seen),
		.beats_seen      (beats_seen),
		.full_reports    (full_reports),
		.empty_reports   (empty_reports)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Drive result ready: random stalls, or a counted hold-off when one is requested
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Bound the run
	initial begin
		#(2_000_000);
		$display("** bounded_double_ended_queue: FAILED **");
		$finish;
	end

	function automatic value_t pick_value();
		case ($urandom_range(9))
		0: begin
			return VALUE_MIN;
		end
		1: begin
			return VALUE_MAX;
		end
		2: begin
			return '0;
		end
		3: begin
			return -1;
		end
		default: begin
			return $urandom;
		end
		endcase
	endfunction

	// Pick an operation; growing favors pushes, shrinking favors pops
	function automatic kind_t pick_kind(input bit growing);
		int r;
		r = $urandom_range(99);
		if (growing) begin
			if (r < 35) return bdeq_pkg::KIND_PUSH_FRONT;
			if (r < 70) return bdeq_pkg::KIND_PUSH_BACK;
			if (r < 80) return bdeq_pkg::KIND_POP_FRONT;
			if (r < 90) return bdeq_pkg::KIND_POP_BACK;
			if (r < 96) return bdeq_pkg::KIND_LIST;
		end else begin
			if (r < 12) return bdeq_pkg::KIND_PUSH_FRONT;
			if (r < 24) return bdeq_pkg::KIND_PUSH_BACK;
			if (r < 54) return bdeq_pkg::KIND_POP_FRONT;
			if (r < 84) return bdeq_pkg::KIND_POP_BACK;
			if (r < 94) return bdeq_pkg::KIND_LIST;
		end
		return kind_t'(bdeq_pkg::KIND_LIST + $urandom_range(1, 3));
	endfunction

	// Offer one request beat after a random idle stretch; hold until taken
	task automatic send_request(input kind_t kind, input value_t value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind  <= kind;
		in_ch.value <= value;
		do
			@(negedge clk);
		while (!in_ch.ready);
		@(posedge clk);
	endtask

	// Run one phase of random requests with the given idle and stall rates
	task automatic run_phase(input int idle_pct, input int stall_pct);
		kind_t kind;
		int    done;
		done = 0;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		while (done < PHASE_ITEMS) begin
			kind = pick_kind(((done / 12) % 2) == 0);
			send_request(kind, pick_value());
			if (kind <= bdeq_pkg::KIND_LIST)
				done++;
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.kind  = bdeq_pkg::KIND_PUSH_FRONT;
		in_ch.value = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Empty queue: list and both pops report empty; unused kinds are dropped
		send_request(bdeq_pkg::KIND_LIST, pick_value());
		send_request(bdeq_pkg::KIND_POP_FRONT, pick_value());
		send_request(bdeq_pkg::KIND_POP_BACK, pick_value());
		send_request(kind_t'(bdeq_pkg::KIND_LIST + 1), VALUE_MAX);
		send_request(kind_t'(bdeq_pkg::KIND_LIST + 3), VALUE_MIN);

		// Lone entry is both front and back
		send_request(bdeq_pkg::KIND_PUSH_FRONT, VALUE_MIN);
		send_request(bdeq_pkg::KIND_POP_BACK, '0);
		send_request(bdeq_pkg::KIND_PUSH_BACK, VALUE_MAX);
		send_request(bdeq_pkg::KIND_POP_FRONT, '0);

		// Fill from both ends, overflow, then list the full ring
		for (int i = 0; i < bdeq_pkg::DEPTH; i++)
			send_request((i % 2) ? bdeq_pkg::KIND_PUSH_BACK : bdeq_pkg::KIND_PUSH_FRONT,
				pick_value());
		send_request(bdeq_pkg::KIND_PUSH_BACK, -1);
		send_request(bdeq_pkg::KIND_LIST, '0);

		// Hold off results while requests keep coming so the block backs up
		@(negedge clk);
		hold_request = 80;
		@(posedge clk);
		send_request(bdeq_pkg::KIND_PUSH_FRONT, 1);
		send_request(bdeq_pkg::KIND_POP_BACK, '0);
		send_request(bdeq_pkg::KIND_POP_FRONT, '0);
		send_request(bdeq_pkg::KIND_LIST, '0);
		send_request(bdeq_pkg::KIND_PUSH_BACK, 2);
		send_request(bdeq_pkg::KIND_POP_BACK, '0);

		// Random phases: no idling, sender idle, receiver stalling, both
		run_phase(0, 0);
		run_phase(71, 0);
		run_phase(0, 71);
		run_phase(38, 38);

		// Drain
		in_ch.valid <= 1'b0;
		recv_stall_pct = 0;
		while (waiting_results != 0)
			@(negedge clk);
		repeat (bdeq_pkg::DEPTH + 8) @(posedge clk);

		$display("Run took %0d requests and checked %0d result beats against the model.",
			requests_seen, beats_seen);
		$display("Reports seen: %0d full, %0d empty; mismatches: %0d.",
			full_reports, empty_reports, error_count);
		if (error_count == 0)
			$display("** bounded_double_ended_queue: PASSED **");
		else
			$display("** bounded_double_ended_queue: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bdeq_pkg.sv
src/bdeq_if.sv
src/bdeq_ctrl.sv
src/bdeq_dp.sv
src/bounded_double_ended_queue.sv
dv/bdeq_checker.sv
dv/tb_bounded_double_ended_queue.sv
